// File: hdl/dtq_pkg.sv
// Shared types, constants and helpers for the deadline timer queue.
package dtq_pkg;

    // Table geometry and time width.
    localparam int NUM_SLOTS   = 16;
    localparam int TIME_BITS   = 48;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;
    typedef logic [SLOT_W-1:0]    slot_idx_t;
    typedef logic [TIME_BITS-1:0] time_t;

    // Request opcodes.
    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_CANCEL  = 3'd1,
        OP_REFRESH = 3'd2,
        OP_RESET   = 3'd3,
        OP_QUERY   = 3'd4,
        OP_EXPIRE  = 3'd5
    } opcode_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_INACTIVE  = 3'd2,
        STAT_UNCHANGED = 3'd3,
        STAT_NONE      = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_REF_WR,
        S_RST_CHK,
        S_RST_SUB,
        S_RST_ADD,
        S_SCAN_PRIME,
        S_SCAN,
        S_POST,
        S_EXP_REARM,
        S_EMIT
    } eng_state_t;

    // What a pass over the table looks at.
    typedef enum logic [1:0] {
        SM_ACTIVE,
        SM_DUE,
        SM_ELIG
    } scan_mode_t;

    // One request as captured at the input.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  slot;
        time_t       period_ms;
        logic        repeat_req;
        logic        rebase_now;
        time_t       now_ms;
    } req_t;

    // One result item.
    typedef struct packed {
        status_t     status;
        logic [3:0]  timer_slot;
        time_t       remaining_ms;
        logic        is_earliest;
        logic        last;
    } res_t;

    // Operands and flags of the shared adder.
    typedef struct packed {
        time_t a;
        time_t b;
        logic  sub;
    } alu_in_t;

    typedef struct packed {
        time_t sum;
        logic  borrow;
        logic  zero;
    } alu_out_t;

    function automatic res_t mk_res(input status_t st, input logic [3:0] sl,
                                    input time_t rem, input logic fr,
                                    input logic la);
        res_t r;
        r.status       = st;
        r.timer_slot   = sl;
        r.remaining_ms = rem;
        r.is_earliest  = fr;
        r.last         = la;
        return r;
    endfunction

endpackage

// File: hdl/dtq_alu.sv
// Shared add, subtract and compare unit used by the steps of the sequencer.
module dtq_alu
    import dtq_pkg::*;
(
    input  alu_in_t  op_in,
    output alu_out_t op_out
);

    logic [TIME_BITS:0] ext;

    // One adder; subtraction adds the inverted operand plus one.
    assign ext = {1'b0, op_in.a}
               + {1'b0, (op_in.sub ? ~op_in.b : op_in.b)}
               + {{TIME_BITS{1'b0}}, op_in.sub};

    // A missing carry on subtraction means a is below b.
    assign op_out.sum    = ext[TIME_BITS-1:0];
    assign op_out.borrow = op_in.sub & ~ext[TIME_BITS];
    assign op_out.zero   = (ext[TIME_BITS-1:0] == '0);

endmodule

// File: hdl/dtq_engine.sv
// Timer table, deadline and period RAMs, and the sequencer that runs each request.
module dtq_engine
    import dtq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic idle,
    input  logic out_free,
    output logic push,
    output res_t res
);

    eng_state_t state_reg, state_next;
    req_t       req_reg;
    scan_mode_t mode_reg, mode_next;
    slot_idx_t  idx_reg, idx_next;
    slot_idx_t  best_idx_reg, best_idx_next;
    time_t      best_dl_reg, best_dl_next;
    logic       found_reg, found_next;
    slot_idx_t  target_reg, target_next;
    time_t      tmp_reg, tmp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    slot_mask_t active_reg, active_next;
    slot_mask_t elig_reg, elig_next;
    slot_mask_t repeat_reg;
    logic       wake_reg, wake_next;
    res_t       res_reg, res_next;

    // Deadline and period storage.
    time_t      dl_mem [NUM_SLOTS];
    time_t      pr_mem [NUM_SLOTS];
    time_t      dl_rd_reg, pr_rd_reg;
    slot_idx_t  dl_raddr, pr_raddr, dl_waddr, pr_waddr;
    time_t      dl_wdata, pr_wdata;
    logic       dl_we, pr_we, rep_we;

    alu_in_t    alu_in;
    alu_out_t   alu_out;

    slot_idx_t  slot_idx, alloc_idx;
    logic       slot_ok, s_active, full, cand_hit, last_idx, last_exp;
    time_t      old_per;
    slot_mask_t elig_clr;

    dtq_alu u_alu (
        .op_in  (alu_in),
        .op_out (alu_out)
    );

    // Decoded views of the captured request and table.
    assign slot_idx = SLOT_W'(req_reg.slot);
    assign slot_ok  = (int'(req_reg.slot) < NUM_SLOTS);
    assign s_active = slot_ok && active_reg[slot_idx];
    assign full     = &active_reg;
    assign old_per  = slot_ok ? pr_rd_reg : '0;
    assign cand_hit = (mode_reg == SM_ACTIVE) ? active_reg[idx_reg] : elig_reg[idx_reg];
    assign last_idx = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign elig_clr = elig_reg & ~(slot_mask_t'(1) << best_idx_reg);
    assign last_exp = (elig_clr == '0) || (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    // Lowest free slot.
    always_comb
    begin
        alloc_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                alloc_idx = SLOT_W'(i);
            end
        end
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_in.a   = req_reg.now_ms;
        alu_in.b   = req_reg.period_ms;
        alu_in.sub = 1'b0;
        case (state_reg)
            S_REF_WR:
            begin
                alu_in.b = pr_rd_reg;
            end
            S_RST_CHK:
            begin
                if (!req_reg.rebase_now)
                begin
                    alu_in.a   = req_reg.period_ms;
                    alu_in.b   = old_per;
                    alu_in.sub = 1'b1;
                end
            end
            S_RST_SUB:
            begin
                alu_in.a   = dl_rd_reg;
                alu_in.b   = old_per;
                alu_in.sub = 1'b1;
            end
            S_RST_ADD:
            begin
                alu_in.a = tmp_reg;
            end
            S_SCAN:
            begin
                alu_in.sub = 1'b1;
                if (mode_reg == SM_DUE)
                begin
                    alu_in.b = dl_rd_reg;
                end
                else
                begin
                    alu_in.a = dl_rd_reg;
                    alu_in.b = best_dl_reg;
                end
            end
            S_POST:
            begin
                alu_in.a   = best_dl_reg;
                alu_in.b   = req_reg.now_ms;
                alu_in.sub = 1'b1;
            end
            S_EXP_REARM:
            begin
                alu_in.b = pr_rd_reg;
            end
            default:
            begin
                alu_in.sub = 1'b0;
            end
        endcase
    end

    // RAM reads: pass index while scanning, best slot for periods in post and rearm, else the addressed slot.
    always_comb
    begin
        case (state_reg)
            S_SCAN_PRIME: dl_raddr = '0;
            S_SCAN:       dl_raddr = idx_reg + SLOT_W'(1);
            default:      dl_raddr = slot_idx;
        endcase
        if (state_reg == S_POST || state_reg == S_EXP_REARM)
        begin
            pr_raddr = best_idx_reg;
        end
        else
        begin
            pr_raddr = slot_idx;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (req_reg.opcode)
                    OP_ADD:     state_next = full ? S_EMIT : S_SCAN_PRIME;
                    OP_CANCEL:  state_next = S_EMIT;
                    OP_REFRESH: state_next = s_active ? S_REF_WR : S_EMIT;
                    OP_RESET:   state_next = S_RST_CHK;
                    OP_QUERY:   state_next = S_SCAN_PRIME;
                    OP_EXPIRE:  state_next = S_SCAN_PRIME;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_REF_WR:
            begin
                state_next = S_EMIT;
            end
            S_RST_CHK:
            begin
                if (req_reg.rebase_now)
                begin
                    state_next = s_active ? S_SCAN_PRIME : S_EMIT;
                end
                else if (alu_out.zero || !s_active)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RST_SUB;
                end
            end
            S_RST_SUB:
            begin
                state_next = S_RST_ADD;
            end
            S_RST_ADD:
            begin
                state_next = S_SCAN_PRIME;
            end
            S_SCAN_PRIME:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (req_reg.opcode == OP_EXPIRE && mode_reg == SM_DUE)
                begin
                    state_next = S_SCAN_PRIME;
                end
                else if (req_reg.opcode == OP_EXPIRE && found_reg &&
                         repeat_reg[best_idx_reg])
                begin
                    state_next = S_EXP_REARM;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EXP_REARM:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = res_reg.last ? S_IDLE : S_SCAN_PRIME;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath updates and RAM writes for each state.
    always_comb
    begin
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_dl_next  = best_dl_reg;
        found_next    = found_reg;
        target_next   = target_reg;
        tmp_next      = tmp_reg;
        cnt_next      = cnt_reg;
        active_next   = active_reg;
        elig_next     = elig_reg;
        wake_next     = wake_reg;
        res_next      = res_reg;
        dl_we         = 1'b0;
        dl_waddr      = slot_idx;
        dl_wdata      = alu_out.sum;
        pr_we         = 1'b0;
        pr_waddr      = slot_idx;
        pr_wdata      = req_reg.period_ms;
        rep_we        = 1'b0;
        push          = 1'b0;
        case (state_reg)
            S_DISPATCH:
            begin
                case (req_reg.opcode)
                    OP_ADD:
                    begin
                        if (full)
                        begin
                            res_next = mk_res(STAT_FULL, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            dl_we                  = 1'b1;
                            dl_waddr               = alloc_idx;
                            pr_we                  = 1'b1;
                            pr_waddr               = alloc_idx;
                            rep_we                 = 1'b1;
                            active_next[alloc_idx] = 1'b1;
                            target_next            = alloc_idx;
                            mode_next              = SM_ACTIVE;
                        end
                    end
                    OP_CANCEL:
                    begin
                        if (s_active)
                        begin
                            active_next[slot_idx] = 1'b0;
                            res_next = mk_res(STAT_OK, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            res_next = mk_res(STAT_INACTIVE, '0, '0, 1'b0, 1'b1);
                        end
                    end
                    OP_REFRESH:
                    begin
                        if (!s_active)
                        begin
                            res_next = mk_res(STAT_INACTIVE, '0, '0, 1'b0, 1'b1);
                        end
                    end
                    OP_QUERY:
                    begin
                        wake_next = 1'b0;
                        mode_next = SM_ACTIVE;
                    end
                    OP_EXPIRE:
                    begin
                        mode_next = SM_DUE;
                        cnt_next  = '0;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            S_REF_WR:
            begin
                // Refresh rearms from now with the stored period.
                dl_we    = 1'b1;
                res_next = mk_res(STAT_OK, '0, '0, 1'b0, 1'b1);
            end
            S_RST_CHK:
            begin
                target_next = slot_idx;
                mode_next   = SM_ACTIVE;
                if (req_reg.rebase_now)
                begin
                    if (s_active)
                    begin
                        dl_we = 1'b1;
                        pr_we = 1'b1;
                    end
                    else
                    begin
                        res_next = mk_res(STAT_INACTIVE, '0, '0, 1'b0, 1'b1);
                    end
                end
                else if (alu_out.zero)
                begin
                    res_next = mk_res(STAT_UNCHANGED, '0, '0, 1'b0, 1'b1);
                end
                else if (!s_active)
                begin
                    res_next = mk_res(STAT_INACTIVE, '0, '0, 1'b0, 1'b1);
                end
            end
            S_RST_SUB:
            begin
                // Back out the old period from the deadline.
                tmp_next = alu_out.sum;
            end
            S_RST_ADD:
            begin
                dl_we = 1'b1;
                pr_we = 1'b1;
            end
            S_SCAN_PRIME:
            begin
                idx_next   = '0;
                found_next = 1'b0;
            end
            S_SCAN:
            begin
                idx_next = idx_reg + SLOT_W'(1);
                if (mode_reg == SM_DUE)
                begin
                    // Due when now is not below the deadline.
                    elig_next[idx_reg] = active_reg[idx_reg] & ~alu_out.borrow;
                end
                else if (cand_hit && (!found_reg || alu_out.borrow))
                begin
                    // Strictly earlier wins, so ties keep the lower slot.
                    best_idx_next = idx_reg;
                    best_dl_next  = dl_rd_reg;
                    found_next    = 1'b1;
                end
            end
            S_POST:
            begin
                case (req_reg.opcode)
                    OP_QUERY:
                    begin
                        if (!found_reg)
                        begin
                            res_next = mk_res(STAT_OK, '0, '1, 1'b0, 1'b1);
                        end
                        else if (alu_out.borrow)
                        begin
                            res_next = mk_res(STAT_OK, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            res_next = mk_res(STAT_OK, '0, alu_out.sum, 1'b0, 1'b1);
                        end
                    end
                    OP_EXPIRE:
                    begin
                        if (mode_reg == SM_DUE)
                        begin
                            mode_next = SM_ELIG;
                        end
                        else if (!found_reg)
                        begin
                            res_next = mk_res(STAT_NONE, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            elig_next = elig_clr;
                            cnt_next  = cnt_reg + CNT_W'(1);
                            res_next  = mk_res(STAT_OK, 4'(best_idx_reg), '0, 1'b0,
                                               last_exp);
                            if (!repeat_reg[best_idx_reg])
                            begin
                                active_next[best_idx_reg] = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        // Add and reset: report whether the slot is now the earliest with no wake-up pending.
                        if (found_reg && best_idx_reg == target_reg && !wake_reg)
                        begin
                            wake_next = 1'b1;
                            res_next  = mk_res(STAT_OK,
                                (req_reg.opcode == OP_ADD) ? 4'(target_reg) : 4'd0,
                                '0, 1'b1, 1'b1);
                        end
                        else
                        begin
                            res_next = mk_res(STAT_OK,
                                (req_reg.opcode == OP_ADD) ? 4'(target_reg) : 4'd0,
                                '0, 1'b0, 1'b1);
                        end
                    end
                endcase
            end
            S_EXP_REARM:
            begin
                dl_we    = 1'b1;
                dl_waddr = best_idx_reg;
            end
            S_EMIT:
            begin
                push = out_free;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= '0;
            wake_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            wake_reg   <= wake_next;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge clk)
    begin
        if (start && state_reg == S_IDLE)
        begin
            req_reg <= req;
        end
        mode_reg     <= mode_next;
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        found_reg    <= found_next;
        target_reg   <= target_next;
        tmp_reg      <= tmp_next;
        cnt_reg      <= cnt_next;
        elig_reg     <= elig_next;
        res_reg      <= res_next;
        if (rep_we)
        begin
            repeat_reg[alloc_idx] <= req_reg.repeat_req;
        end
    end

    // Deadline RAM.
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[dl_waddr] <= dl_wdata;
        end
        dl_rd_reg <= dl_mem[dl_raddr];
    end

    // Period RAM.
    always_ff @(posedge clk)
    begin
        if (pr_we)
        begin
            pr_mem[pr_waddr] <= pr_wdata;
        end
        pr_rd_reg <= pr_mem[pr_raddr];
    end

    assign idle = (state_reg == S_IDLE);
    assign res  = res_reg;

endmodule

// File: hdl/deadline_timer_queue.sv
// Top level of the deadline timer queue: request handshake and result register.
//
// A table of sixteen timer slots driven by requests that carry an opcode and the current
// time: add, cancel, refresh, reset period, query time to the next deadline, and expire.
// Deadlines and periods sit in two small RAMs, and a sequencer walks them one slot per
// clock through a single shared adder that also serves as the comparator. A cancel, a
// refresh and a failed add or reset make no pass over the deadline RAM. An add, a
// successful reset and a query each make one pass over it. An expire makes one pass to
// mark the due slots and then one pass for each slot it emits, or a single pass when
// nothing is due, and rearms each repeating slot that it emits. Results go out through
// a one-entry output register; the sequencer waits while it is still full, and a new
// request is taken only when the previous one has been fully worked off.
module deadline_timer_queue
    import dtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [3:0]  slot,
    input  time_t       period_ms,
    input  logic        repeat_req,
    input  logic        rebase_now,
    input  time_t       now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  timer_slot,
    output time_t       remaining_ms,
    output logic        is_earliest,
    output logic        last
);

    req_t req;
    res_t eng_res;
    res_t res_reg;
    logic out_valid_reg;
    logic eng_idle, eng_push, out_free;

    // Gather the request fields.
    assign req.opcode     = opcode;
    assign req.slot       = slot;
    assign req.period_ms  = period_ms;
    assign req.repeat_req = repeat_req;
    assign req.rebase_now = rebase_now;
    assign req.now_ms     = now_ms;

    assign in_ready = eng_idle;
    assign out_free = !out_valid_reg || out_ready;

    dtq_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid && in_ready),
        .req      (req),
        .idle     (eng_idle),
        .out_free (out_free),
        .push     (eng_push),
        .res      (eng_res)
    );

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (eng_push)
        begin
            res_reg <= eng_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign timer_slot   = res_reg.timer_slot;
    assign remaining_ms = res_reg.remaining_ms;
    assign is_earliest  = res_reg.is_earliest;
    assign last         = res_reg.last;

    // The sequencer only loads a result when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n) eng_push |-> out_free)
        else $error("result pushed into a full output register");

    // An accepted request keeps the block busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while the previous one was starting");

    // A front indication only comes with a successful add or reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_earliest) |-> (status == STAT_OK))
        else $error("front flag on a failed result");

endmodule

// File: bench/tb.sv
// Self-checking testbench for the deadline timer queue: directed and random timer requests.
`timescale 1ns / 100ps

module tb
    import dtq_pkg::*;
();

    // The two opcodes that the block must ignore.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS   = 230;
    localparam int SETTLE_CYCLES  = 64;
    localparam time_t TIME_ALL_ONES = '1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = '0;
    logic [3:0]  slot = '0;
    time_t       period_ms = '0;
    logic        repeat_req = 1'b0;
    logic        rebase_now = 1'b0;
    time_t       now_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [3:0]  timer_slot;
    time_t       remaining_ms;
    logic        is_earliest;
    logic        last;

    // Predicted copy of the timer table.
    logic        tm_active [NUM_SLOTS] = '{default: 1'b0};
    logic        tm_repeat [NUM_SLOTS] = '{default: 1'b0};
    time_t       tm_period [NUM_SLOTS] = '{default: '0};
    time_t       tm_deadline [NUM_SLOTS] = '{default: '0};
    logic        tm_written [NUM_SLOTS] = '{default: 1'b0};
    logic        tm_wake = 1'b0;

    res_t        expected_results [$];
    int          error_count = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          hold_left = 0;
    time_t       tnow = '0;

    deadline_timer_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .slot         (slot),
        .period_ms    (period_ms),
        .repeat_req   (repeat_req),
        .rebase_now   (rebase_now),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .timer_slot   (timer_slot),
        .remaining_ms (remaining_ms),
        .is_earliest  (is_earliest),
        .last         (last)
    );

    // Clock generation.
    always #2 clk = ~clk;

    // Watchdog for a hung run.
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic time_t rnd48();
        return time_t'({$urandom, $urandom});
    endfunction

    // Periods are mostly short so that expires find many slots due.
    function automatic time_t random_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return time_t'($urandom_range(0, 120));
        else if (r < 9)
            return time_t'($urandom_range(0, 1000));
        return rnd48();
    endfunction

    // Returns an armed slot, or one that has held a period, or -1 if none.
    function automatic int pick_slot(bit any_written);
        int cand [$];
        int j;
        for (j = 0; j < NUM_SLOTS; j++)
            if (any_written ? tm_written[j] : tm_active[j])
                cand = {cand, j};
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Deadline order with ties going to the lower slot.
    function automatic bit earlier(int a, int b);
        if (tm_deadline[a] != tm_deadline[b])
            return tm_deadline[a] < tm_deadline[b];
        return a < b;
    endfunction

    // The slot is now the earliest and no wake-up is pending: signal it.
    function automatic bit claim_front(int s);
        int j;
        for (j = 0; j < NUM_SLOTS; j++)
            if (j != s && tm_active[j] && earlier(j, s))
                return 1'b0;
        if (tm_wake)
            return 1'b0;
        tm_wake = 1'b1;
        return 1'b1;
    endfunction

    task automatic record_expected(input status_t st, input int sl, input time_t rem,
                                   input bit fr, input bit la);
        res_t r;
        r.status       = st;
        r.timer_slot   = sl[3:0];
        r.remaining_ms = rem;
        r.is_earliest  = fr;
        r.last         = la;
        expected_results = {expected_results, r};
    endtask

    // Updates the predicted table for one accepted request and queues its results.
    task automatic predict_timer_op(input logic [2:0] op, input logic [3:0] s,
                                    input time_t per, input logic rq, input logic fn,
                                    input time_t now);
        int    j;
        int    k;
        int    n;
        int    best;
        bit    found;
        bit    taken [NUM_SLOTS];
        int    due_list [MAX_RESULTS];
        time_t old;
        time_t rem;
        case (op)
            OP_ADD:
            begin
                for (j = 0; j < NUM_SLOTS; j++)
                    if (!tm_active[j])
                        break;
                if (j >= NUM_SLOTS)
                    record_expected(STAT_FULL, 0, '0, 1'b0, 1'b1);
                else
                begin
                    tm_active[j]   = 1'b1;
                    tm_repeat[j]   = rq;
                    tm_period[j]   = per;
                    tm_deadline[j] = now + per;
                    tm_written[j]  = 1'b1;
                    record_expected(STAT_OK, j, '0, claim_front(j), 1'b1);
                end
            end
            OP_CANCEL:
            begin
                if (!tm_active[s])
                    record_expected(STAT_INACTIVE, 0, '0, 1'b0, 1'b1);
                else
                begin
                    tm_active[s] = 1'b0;
                    record_expected(STAT_OK, 0, '0, 1'b0, 1'b1);
                end
            end
            OP_REFRESH:
            begin
                if (!tm_active[s])
                    record_expected(STAT_INACTIVE, 0, '0, 1'b0, 1'b1);
                else
                begin
                    tm_deadline[s] = now + tm_period[s];
                    record_expected(STAT_OK, 0, '0, 1'b0, 1'b1);
                end
            end
            OP_RESET:
            begin
                // The unchanged test comes first, so a freed slot can report it too.
                old = tm_period[s];
                if (per == old && !fn)
                    record_expected(STAT_UNCHANGED, 0, '0, 1'b0, 1'b1);
                else if (!tm_active[s])
                    record_expected(STAT_INACTIVE, 0, '0, 1'b0, 1'b1);
                else
                begin
                    if (fn)
                        tm_deadline[s] = now + per;
                    else
                        tm_deadline[s] = tm_deadline[s] - old + per;
                    tm_period[s] = per;
                    record_expected(STAT_OK, 0, '0, claim_front(s), 1'b1);
                end
            end
            OP_QUERY:
            begin
                tm_wake = 1'b0;
                found = 1'b0;
                best = 0;
                for (j = 0; j < NUM_SLOTS; j++)
                    if (tm_active[j] && (!found || earlier(j, best)))
                    begin
                        best = j;
                        found = 1'b1;
                    end
                if (!found)
                    rem = TIME_ALL_ONES;
                else if (now >= tm_deadline[best])
                    rem = '0;
                else
                    rem = tm_deadline[best] - now;
                record_expected(STAT_OK, 0, rem, 1'b0, 1'b1);
            end
            OP_EXPIRE:
            begin
                // Pick the due slots in deadline order, then rearm or free them.
                n = 0;
                for (j = 0; j < NUM_SLOTS; j++)
                    taken[j] = 1'b0;
                while (n < MAX_RESULTS)
                begin
                    found = 1'b0;
                    best = 0;
                    for (j = 0; j < NUM_SLOTS; j++)
                        if (tm_active[j] && !taken[j] && tm_deadline[j] <= now &&
                            (!found || earlier(j, best)))
                        begin
                            best = j;
                            found = 1'b1;
                        end
                    if (!found)
                        break;
                    taken[best] = 1'b1;
                    due_list[n] = best;
                    n++;
                end
                if (n == 0)
                    record_expected(STAT_NONE, 0, '0, 1'b0, 1'b1);
                for (k = 0; k < n; k++)
                begin
                    if (tm_repeat[due_list[k]])
                        tm_deadline[due_list[k]] = now + tm_period[due_list[k]];
                    else
                        tm_active[due_list[k]] = 1'b0;
                    record_expected(STAT_OK, due_list[k], '0, 1'b0, k == n - 1);
                end
            end
            default:
            begin
                // Spare opcodes cause nothing.
            end
        endcase
    endtask

    // Sends one request, with an optional idle burst before it.
    task automatic send_req(input logic [2:0] op, input logic [3:0] s, input time_t per,
                            input logic rq, input logic fn, input time_t now);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        slot       <= s;
        period_ms  <= per;
        repeat_req <= rq;
        rebase_now <= fn;
        now_ms     <= now;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        predict_timer_op(op, s, per, rq, fn, now);
    endtask

    // Stops sending and waits until every queued result has come back.
    task automatic wait_results_drained(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("tb: mismatch in %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    // Empty table: query, nothing due, inactive slot and a spare opcode.
    task automatic test_empty_table();
        send_req(OP_QUERY, 4'd0, rnd48(), 1'b1, 1'b1, 48'd0);
        send_req(OP_EXPIRE, 4'd9, rnd48(), 1'b0, 1'b1, TIME_ALL_ONES);
        send_req(OP_CANCEL, 4'd15, rnd48(), 1'b1, 1'b0, 48'd5);
        send_req(OP_SPARE_7, 4'd15, TIME_ALL_ONES, 1'b1, 1'b1, TIME_ALL_ONES);
        wait_results_drained(SETTLE_CYCLES);
    endtask

    // Front signalling, every reset outcome, and refresh.
    task automatic test_front_and_reset();
        send_req(OP_ADD, 4'd7, 48'd100, 1'b1, 1'b0, 48'd1000);
        send_req(OP_ADD, 4'd3, 48'd50, 1'b0, 1'b1, 48'd1000);
        send_req(OP_QUERY, 4'd0, '0, 1'b0, 1'b0, 48'd1000);
        send_req(OP_RESET, 4'd0, 48'd100, 1'b0, 1'b0, 48'd1005);
        send_req(OP_RESET, 4'd1, 48'd20, 1'b0, 1'b0, 48'd1010);
        send_req(OP_EXPIRE, 4'd0, '0, 1'b0, 1'b0, 48'd1020);
        // A freed slot still keeps its period for the unchanged test.
        send_req(OP_RESET, 4'd1, 48'd20, 1'b0, 1'b0, 48'd1030);
        send_req(OP_RESET, 4'd1, 48'd30, 1'b0, 1'b1, 48'd1030);
        send_req(OP_REFRESH, 4'd0, rnd48(), 1'b1, 1'b1, 48'd2000);
        wait_results_drained(SETTLE_CYCLES);
    endtask

    // Fill the table near the top of the time range, then expire everything.
    task automatic test_table_full();
        int i;
        for (i = 0; i < NUM_SLOTS - 1; i++)
            send_req(OP_ADD, 4'(i), (i == NUM_SLOTS - 2) ? TIME_ALL_ONES : time_t'(i % 4),
                     1'(i), 1'b0, 48'hFFFF_FFFF_FFF0);
        send_req(OP_ADD, 4'd0, 48'd1, 1'b1, 1'b1, 48'hFFFF_FFFF_FFF0);
        send_req(OP_EXPIRE, 4'd0, rnd48(), 1'b0, 1'b0, TIME_ALL_ONES);
        wait_results_drained(SETTLE_CYCLES);
    endtask

    // Random mix of all requests with moving time and biased slot choice.
    task automatic test_random_traffic();
        int          n;
        int          r;
        int          s;
        logic [2:0]  op;
        time_t       per;
        logic        fn;
        tnow = 48'd5000;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Hold off once until the block has worked everything off.
            if (n == RANDOM_ITEMS / 2)
                wait_results_drained(0);
            if (n == RANDOM_ITEMS - 40)
            begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            if ($urandom_range(0, 49) == 0)
                tnow = rnd48();
            else if ($urandom_range(0, 4) == 0)
                tnow += time_t'($urandom_range(0, 300));
            else
                tnow += time_t'($urandom_range(0, 30));
            per = rnd48();
            fn = 1'($urandom_range(0, 1));
            s = $urandom_range(0, NUM_SLOTS - 1);
            r = $urandom_range(0, 99);
            if (r < 24)
            begin
                op = OP_ADD;
                per = random_period();
            end
            else if (r < 48)
                op = OP_EXPIRE;
            else if (r < 62)
                op = OP_QUERY;
            else if (r < 82)
            begin
                op = (r < 72) ? OP_CANCEL : OP_REFRESH;
                s = pick_slot(1'b0);
                if (s < 0 || $urandom_range(0, 3) == 0)
                    s = $urandom_range(0, NUM_SLOTS - 1);
            end
            else if (r < 95)
            begin
                // Reset only slots that have held a period.
                s = pick_slot(1'b1);
                if (s < 0)
                begin
                    op = OP_ADD;
                    s = 0;
                    per = random_period();
                end
                else
                begin
                    op = OP_RESET;
                    per = ($urandom_range(0, 2) == 0) ? tm_period[s] : random_period();
                end
            end
            else
                op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
            send_req(op, 4'(s), per, 1'($urandom_range(0, 1)), fn, tnow);
        end
        wait_results_drained(SETTLE_CYCLES);
    endtask

    // Receiver stalls in random bursts.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            hold_left <= $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Result checker: values are stable at the falling edge before acceptance.
    always @(negedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, slot", timer_slot, 0);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (timer_slot !== want.timer_slot)
                    report_mismatch("timer_slot", timer_slot, want.timer_slot);
                if (remaining_ms !== want.remaining_ms)
                    report_mismatch("remaining_ms", remaining_ms, want.remaining_ms);
                if (is_earliest !== want.is_earliest)
                    report_mismatch("is_earliest", is_earliest, want.is_earliest);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    // Reset, then the tests in turn.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_front_and_reset();
        test_table_full();
        test_random_traffic();
        if (expected_results.size() != 0)
            report_mismatch("results left over, count", expected_results.size(), 0);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
